>>> hw/rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the edge taper block.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define HET_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define HET_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hw/rtl/het_pkg.sv
// ---------------------------------------------------------------------------
// het_pkg
// Types, constants and tables shared by the edge taper modules.
// ---------------------------------------------------------------------------
package het_pkg;

  localparam int MAX_FRAME_DEF      = 65536;
  localparam int SAMPLE_BITS_DEF    = 24;
  localparam int COEF_FRAC_BITS_DEF = 17;

  localparam int LEN_W        = 17;
  localparam int FRAC_W       = 16;
  localparam int TAPER_W      = 16;
  localparam int PHASE_W      = 32;
  localparam int ADDR_W       = 3;
  localparam int DATA_W       = 32;
  localparam int CORDIC_ITERS = 20;
  localparam int ITER_W       = $clog2(CORDIC_ITERS);
  localparam int DIV_STEPS    = PHASE_W + 1;
  localparam int CNT_W        = $clog2(DIV_STEPS);
  localparam int CORDIC_W     = 33;

  localparam logic [LEN_W-1:0]  FRAME_LENGTH_RST = LEN_W'(1024);
  localparam logic [FRAC_W-1:0] TAPER_FRAC_RST   = FRAC_W'(3277);
  localparam logic [FRAC_W-1:0] FRAC_HALF        = FRAC_W'(32768);

  // Gain-compensated start vector, Q2.30.
  localparam logic signed [CORDIC_W-1:0] CORDIC_X0 = 33'sh026DD3B6A;
  // Window 0.54 - 0.46*cos, both terms in Q.30.
  localparam logic signed [30:0] WIN_MUL = 31'sd493921239;
  localparam logic signed [63:0] WIN_OFS = 64'sd579820585;

  typedef enum logic [0:0] {
    REG_FRAME_LENGTH   = 1'b0,
    REG_TAPER_FRACTION = 1'b1
  } het_reg_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LATCH,
    ST_DIV,
    ST_EDGE,
    ST_PHASE,
    ST_CORDIC,
    ST_COS,
    ST_WMUL,
    ST_WCALC,
    ST_SMUL,
    ST_OUT
  } het_state_t;

  typedef struct packed {
    logic              accept;
    logic              latch_taper;
    logic              div_init;
    logic              div_step;
    logic              div_lead;
    logic              edge_calc;
    logic              phase_load;
    logic              cordic_step;
    logic              cos_sel;
    logic              wmul;
    logic              wcalc;
    logic              smul;
    logic              out_load;
    logic [ITER_W-1:0] iter;
  } het_cmd_t;

  typedef struct packed {
    logic p_zero;
    logic edge_hit;
    logic out_full;
  } het_sts_t;

  // atan(2^-i) in units of 2^-32 turn.
  function automatic logic [PHASE_W-1:0] atan_turn(input logic [ITER_W-1:0] i);
    logic [PHASE_W-1:0] a;
    case (i)
      5'd0:    a = 32'h20000000;
      5'd1:    a = 32'h12E4051E;
      5'd2:    a = 32'h09FB385B;
      5'd3:    a = 32'h051111D4;
      5'd4:    a = 32'h028B0D43;
      5'd5:    a = 32'h0145D7E1;
      5'd6:    a = 32'h00A2F61E;
      5'd7:    a = 32'h00517C55;
      5'd8:    a = 32'h0028BE53;
      5'd9:    a = 32'h00145F2F;
      5'd10:   a = 32'h000A2F98;
      5'd11:   a = 32'h000517CC;
      5'd12:   a = 32'h00028BE6;
      5'd13:   a = 32'h000145F3;
      5'd14:   a = 32'h0000A2FA;
      5'd15:   a = 32'h0000517D;
      5'd16:   a = 32'h000028BE;
      5'd17:   a = 32'h0000145F;
      5'd18:   a = 32'h00000A30;
      5'd19:   a = 32'h00000518;
      default: a = '0;
    endcase
    return a;
  endfunction

endpackage

>>> hw/rtl/het_in_if.sv
// ---------------------------------------------------------------------------
// het_in_if
// Input sample channel: valid/ready handshake with sample and frame marker.
// ---------------------------------------------------------------------------
interface het_in_if #(
  parameter int SAMPLE_BITS = het_pkg::SAMPLE_BITS_DEF
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample;
  logic                          frame_start;

  modport source (output valid, output sample, output frame_start, input ready);
  modport sink   (input valid, input sample, input frame_start, output ready);
endinterface

>>> hw/rtl/het_out_if.sv
// ---------------------------------------------------------------------------
// het_out_if
// Result channel: valid/ready handshake with tapered sample and frame end.
// ---------------------------------------------------------------------------
interface het_out_if #(
  parameter int SAMPLE_BITS = het_pkg::SAMPLE_BITS_DEF
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] tapered_sample;
  logic                          frame_end;

  modport source (output valid, output tapered_sample, output frame_end, input ready);
  modport sink   (input valid, input tapered_sample, input frame_end, output ready);
endinterface

>>> hw/rtl/hamming_edge_taper.sv
// ---------------------------------------------------------------------------
// hamming_edge_taper
// Hamming taper on the first and last samples of each frame.
// ---------------------------------------------------------------------------
// The block takes one sample at a time and returns one tapered sample for each.
// A sample in the untapered middle of a frame passes the latch, edge, phase and
// output states; a tapered edge sample also runs the 20-step CORDIC that
// computes its cosine, followed by the window and sample multiplies.
// The first sample of every frame also runs the bit-serial divider that
// computes the phase step from the latched taper length. Results wait in
// an output register, so the next sample is taken while a result is unread.
// Register frame_length sits at byte address 0 and taper_fraction at 4; write
// them only while the block is idle.
module hamming_edge_taper #(
  parameter int MAX_FRAME      = het_pkg::MAX_FRAME_DEF,
  parameter int SAMPLE_BITS    = het_pkg::SAMPLE_BITS_DEF,
  parameter int COEF_FRAC_BITS = het_pkg::COEF_FRAC_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  het_in_if.sink                       in_ch,
  het_out_if.source                    out_ch,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [het_pkg::ADDR_W-1:0]   paddr,
  input  logic [het_pkg::DATA_W-1:0]   pwdata,
  output logic [het_pkg::DATA_W-1:0]   prdata,
  output logic                         pready
);
  import het_pkg::*;

  `include "assert_macros.svh"

  logic [LEN_W-1:0]  frame_length_r, frame_length_nxt;
  logic [FRAC_W-1:0] taper_fraction_r, taper_fraction_nxt;
  logic              cfg_wr;
  het_reg_t          reg_sel;
  het_cmd_t          cmd;
  het_sts_t          sts;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign reg_sel = het_reg_t'(paddr[2]);

  always_comb begin
    frame_length_nxt   = frame_length_r;
    taper_fraction_nxt = taper_fraction_r;
    if (cfg_wr) begin
      case (reg_sel)
        REG_FRAME_LENGTH:   frame_length_nxt   = pwdata[LEN_W-1:0];
        REG_TAPER_FRACTION: taper_fraction_nxt = pwdata[FRAC_W-1:0];
        default: begin
          frame_length_nxt = frame_length_r;
        end
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_FRAME_LENGTH:   prdata = DATA_W'(frame_length_r);
      REG_TAPER_FRACTION: prdata = DATA_W'(taper_fraction_r);
      default:            prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_length_r   <= FRAME_LENGTH_RST;
      taper_fraction_r <= TAPER_FRAC_RST;
    end else begin
      frame_length_r   <= frame_length_nxt;
      taper_fraction_r <= taper_fraction_nxt;
    end
  end

  het_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  het_dpath #(
    .MAX_FRAME      (MAX_FRAME),
    .SAMPLE_BITS    (SAMPLE_BITS),
    .COEF_FRAC_BITS (COEF_FRAC_BITS)
  ) u_dpath (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .sts                (sts),
    .frame_length       (frame_length_r),
    .taper_fraction     (taper_fraction_r),
    .in_sample          (in_ch.sample),
    .in_frame_start     (in_ch.frame_start),
    .out_ready          (out_ch.ready),
    .out_valid          (out_ch.valid),
    .out_tapered_sample (out_ch.tapered_sample),
    .out_frame_end      (out_ch.frame_end)
  );

  // Only one sample is in flight, so an accepted beat closes the input.
  `HET_ASSERT_NEXT(a_one_in_flight, clk, rst_n, in_ch.valid && in_ch.ready, !in_ch.ready, "input accepted while a sample is in flight")
  // A result must never overwrite one that is still waiting to be taken.
  `HET_ASSERT_NOW(a_no_overwrite, clk, rst_n, cmd.out_load, !out_ch.valid || out_ch.ready, "output register overwritten before it was taken")
  // A new sample is only taken after the previous result was loaded, never during a divider or CORDIC step.
  `HET_ASSERT_NOW(a_accept_idle, clk, rst_n, cmd.accept, !cmd.div_step && !cmd.cordic_step, "sample accepted during an iteration")

endmodule

>>> hw/rtl/het_div.sv
// ---------------------------------------------------------------------------
// het_div
// Restoring divider, one quotient bit per step, for the CORDIC phase step.
// ---------------------------------------------------------------------------
module het_div #(
  parameter int DIV_W = het_pkg::LEN_W,
  parameter int Q_W   = het_pkg::PHASE_W
) (
  input  logic             clk,
  input  logic             init,
  input  logic             step,
  input  logic             bit_in,
  input  logic [DIV_W-1:0] divisor,
  output logic [Q_W-1:0]   quotient
);
  import het_pkg::*;

  logic [DIV_W-1:0] rem_r, rem_nxt;
  logic [Q_W-1:0]   quot_r, quot_nxt;
  logic [DIV_W:0]   shifted;
  logic [DIV_W:0]   diff;

  always_comb begin
    shifted  = {rem_r, bit_in};
    diff     = shifted - {1'b0, divisor};
    rem_nxt  = rem_r;
    quot_nxt = quot_r;
    if (init) begin
      rem_nxt = '0;
    end else if (step) begin
      if (shifted >= {1'b0, divisor}) begin
        rem_nxt  = diff[DIV_W-1:0];
        quot_nxt = {quot_r[Q_W-2:0], 1'b1};
      end else begin
        rem_nxt  = shifted[DIV_W-1:0];
        quot_nxt = {quot_r[Q_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    rem_r  <= rem_nxt;
    quot_r <= quot_nxt;
  end

  // The quotient bit above Q_W falls off the top, giving the result mod 2^Q_W.
  assign quotient = quot_r;

endmodule

>>> hw/rtl/het_ctrl.sv
// ---------------------------------------------------------------------------
// het_ctrl
// Sequencer for one sample: taper latch, divide, CORDIC and weighting steps.
// ---------------------------------------------------------------------------
module het_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  het_pkg::het_sts_t sts,
  output het_pkg::het_cmd_t cmd
);
  import het_pkg::*;

  het_state_t       state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    in_ready  = 1'b0;
    cmd       = '0;
    cmd.iter  = cnt_r[ITER_W-1:0];
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = ST_LATCH;
        end
      end
      ST_LATCH: begin
        if (sts.p_zero) begin
          cmd.latch_taper = 1'b1;
          cmd.div_init    = 1'b1;
          cnt_nxt         = '0;
          state_nxt       = ST_DIV;
        end else begin
          state_nxt = ST_EDGE;
        end
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        cmd.div_lead = (cnt_r == '0);
        if (cnt_r == CNT_W'(DIV_STEPS - 1)) begin
          state_nxt = ST_EDGE;
        end else begin
          cnt_nxt = cnt_r + CNT_W'(1);
        end
      end
      ST_EDGE: begin
        cmd.edge_calc = 1'b1;
        state_nxt     = ST_PHASE;
      end
      ST_PHASE: begin
        if (sts.edge_hit) begin
          cmd.phase_load = 1'b1;
          cnt_nxt        = '0;
          state_nxt      = ST_CORDIC;
        end else begin
          state_nxt = ST_OUT;
        end
      end
      ST_CORDIC: begin
        cmd.cordic_step = 1'b1;
        if (cnt_r == CNT_W'(CORDIC_ITERS - 1)) begin
          state_nxt = ST_COS;
        end else begin
          cnt_nxt = cnt_r + CNT_W'(1);
        end
      end
      ST_COS: begin
        cmd.cos_sel = 1'b1;
        state_nxt   = ST_WMUL;
      end
      ST_WMUL: begin
        cmd.wmul  = 1'b1;
        state_nxt = ST_WCALC;
      end
      ST_WCALC: begin
        cmd.wcalc = 1'b1;
        state_nxt = ST_SMUL;
      end
      ST_SMUL: begin
        cmd.smul  = 1'b1;
        state_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (!sts.out_full) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

>>> hw/rtl/het_dpath.sv
// ---------------------------------------------------------------------------
// het_dpath
// Position tracking, taper latch, CORDIC cosine, window and output register.
// ---------------------------------------------------------------------------
module het_dpath #(
  parameter int MAX_FRAME      = het_pkg::MAX_FRAME_DEF,
  parameter int SAMPLE_BITS    = het_pkg::SAMPLE_BITS_DEF,
  parameter int COEF_FRAC_BITS = het_pkg::COEF_FRAC_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  het_pkg::het_cmd_t                cmd,
  output het_pkg::het_sts_t                sts,
  input  logic [het_pkg::LEN_W-1:0]        frame_length,
  input  logic [het_pkg::FRAC_W-1:0]       taper_fraction,
  input  logic signed [SAMPLE_BITS-1:0]    in_sample,
  input  logic                             in_frame_start,
  input  logic                             out_ready,
  output logic                             out_valid,
  output logic signed [SAMPLE_BITS-1:0]    out_tapered_sample,
  output logic                             out_frame_end
);
  import het_pkg::*;

  localparam int F    = COEF_FRAC_BITS;
  localparam int SPW  = SAMPLE_BITS + F + 2;
  localparam int KPW  = LEN_W + PHASE_W;
  localparam int SW_W = LEN_W + 2;

  localparam logic signed [63:0]    HALF30 = 64'sd1 <<< 29;
  localparam logic signed [63:0]    HALFW  = 64'sd1 <<< (29 - F);
  localparam logic signed [63:0]    WMAX   = 64'sd1 <<< F;
  localparam logic signed [SPW-1:0] HALFS  = SPW'(1) <<< (F - 1);
  localparam logic signed [SPW-1:0] SMAX   = (SPW'(1) <<< (SAMPLE_BITS - 1)) - SPW'(1);
  localparam logic signed [SPW-1:0] SMIN   = -(SPW'(1) <<< (SAMPLE_BITS - 1));

  // Frame position and per-item control.
  logic [LEN_W-1:0] pos_r, pos_nxt;
  logic             out_valid_r, out_valid_nxt;

  // Payload registers.
  logic signed [SAMPLE_BITS-1:0] sample_r, sample_nxt;
  logic [LEN_W-1:0]              p_r, p_nxt;
  logic [LEN_W-1:0]              len_r, len_nxt;
  logic                          fend_r, fend_nxt;
  logic [TAPER_W-1:0]            taper_r, taper_nxt;
  logic                          edge_r, edge_nxt;
  logic [LEN_W-1:0]              k_r, k_nxt;
  logic [1:0]                    quad_r, quad_nxt;
  logic signed [CORDIC_W-1:0]    x_r, x_nxt;
  logic signed [CORDIC_W-1:0]    y_r, y_nxt;
  logic signed [CORDIC_W-1:0]    z_r, z_nxt;
  logic signed [CORDIC_W-1:0]    cos_r, cos_nxt;
  logic signed [63:0]            prod_r, prod_nxt;
  logic [F:0]                    w_r, w_nxt;
  logic signed [SPW-1:0]         sp_r, sp_nxt;
  logic signed [SAMPLE_BITS-1:0] res_r, res_nxt;
  logic                          oend_r, oend_nxt;

  // Combinational terms.
  logic [LEN_W-1:0]            len_eff;
  logic [LEN_W-1:0]            p_sel;
  logic [LEN_W:0]              p_inc;
  logic [FRAC_W-1:0]           frac_c;
  logic [LEN_W+FRAC_W-1:0]     t_prod;
  logic [PHASE_W-1:0]          phase_step;
  logic [LEN_W-1:0]            divisor;
  logic signed [SW_W-1:0]      pe, le, te, kd;
  logic                        lo_hit, hi_hit;
  logic [KPW-1:0]              ph_full;
  logic signed [CORDIC_W-1:0]  dx, dy, at;
  logic signed [63:0]          t_rnd, w30, w_sh;
  logic signed [SPW-1:0]       s_rnd, s_sh;
  logic signed [SAMPLE_BITS-1:0] s_sat;

  het_div #(
    .DIV_W (LEN_W),
    .Q_W   (PHASE_W)
  ) u_div (
    .clk      (clk),
    .init     (cmd.div_init),
    .step     (cmd.div_step),
    .bit_in   (cmd.div_lead),
    .divisor  (divisor),
    .quotient (phase_step)
  );

  assign divisor = {taper_r, 1'b0} - LEN_W'(1);

  always_comb begin
    len_eff = frame_length;
    if (frame_length == '0) begin
      len_eff = LEN_W'(1);
    end else if (32'(frame_length) > 32'(MAX_FRAME)) begin
      len_eff = LEN_W'(MAX_FRAME);
    end
    // A position past a shrunken length starts a new frame.
    p_sel  = (in_frame_start || (pos_r >= len_eff)) ? '0 : pos_r;
    p_inc  = {1'b0, p_sel} + (LEN_W + 1)'(1);
    frac_c = (taper_fraction > FRAC_HALF) ? FRAC_HALF : taper_fraction;
    t_prod = len_r * frac_c;

    pe     = $signed({2'b0, p_r});
    le     = $signed({2'b0, len_r});
    te     = $signed({3'b0, taper_r});
    lo_hit = ({1'b0, taper_r} > p_r);
    hi_hit = (pe >= (le - te));
    kd     = pe - le + (te <<< 1);

    ph_full = k_r * phase_step;

    dx = y_r >>> cmd.iter;
    dy = x_r >>> cmd.iter;
    at = $signed({1'b0, atan_turn(cmd.iter)});

    t_rnd = (prod_r + HALF30) >>> 30;
    w30   = WIN_OFS - t_rnd;
    w_sh  = (w30 + HALFW) >>> (30 - F);

    s_rnd = sp_r + HALFS;
    s_sh  = s_rnd >>> F;
    if (s_sh > SMAX) begin
      s_sat = SMAX[SAMPLE_BITS-1:0];
    end else if (s_sh < SMIN) begin
      s_sat = SMIN[SAMPLE_BITS-1:0];
    end else begin
      s_sat = s_sh[SAMPLE_BITS-1:0];
    end
  end

  always_comb begin
    pos_nxt       = pos_r;
    sample_nxt    = sample_r;
    p_nxt         = p_r;
    len_nxt       = len_r;
    fend_nxt      = fend_r;
    taper_nxt     = taper_r;
    edge_nxt      = edge_r;
    k_nxt         = k_r;
    quad_nxt      = quad_r;
    x_nxt         = x_r;
    y_nxt         = y_r;
    z_nxt         = z_r;
    cos_nxt       = cos_r;
    prod_nxt      = prod_r;
    w_nxt         = w_r;
    sp_nxt        = sp_r;
    res_nxt       = res_r;
    oend_nxt      = oend_r;
    out_valid_nxt = out_valid_r && !out_ready;

    if (cmd.accept) begin
      sample_nxt = in_sample;
      p_nxt      = p_sel;
      len_nxt    = len_eff;
      fend_nxt   = (p_inc == {1'b0, len_eff});
      pos_nxt    = (p_inc >= {1'b0, len_eff}) ? '0 : p_inc[LEN_W-1:0];
    end
    if (cmd.latch_taper) begin
      taper_nxt = t_prod[FRAC_W +: TAPER_W];
    end
    if (cmd.edge_calc) begin
      edge_nxt = (taper_r != '0) && (lo_hit || hi_hit);
      k_nxt    = lo_hit ? p_r : kd[LEN_W-1:0];
    end
    if (cmd.phase_load) begin
      quad_nxt = ph_full[PHASE_W-1 -: 2];
      x_nxt    = CORDIC_X0;
      y_nxt    = '0;
      z_nxt    = $signed({3'b0, ph_full[PHASE_W-3:0]});
    end
    if (cmd.cordic_step) begin
      if (!z_r[CORDIC_W-1]) begin
        x_nxt = x_r - dx;
        y_nxt = y_r + dy;
        z_nxt = z_r - at;
      end else begin
        x_nxt = x_r + dx;
        y_nxt = y_r - dy;
        z_nxt = z_r + at;
      end
    end
    if (cmd.cos_sel) begin
      case (quad_r)
        2'd0:    cos_nxt = x_r;
        2'd1:    cos_nxt = -y_r;
        2'd2:    cos_nxt = -x_r;
        default: cos_nxt = y_r;
      endcase
    end
    if (cmd.wmul) begin
      prod_nxt = cos_r * WIN_MUL;
    end
    if (cmd.wcalc) begin
      if (w_sh < 64'sd0) begin
        w_nxt = '0;
      end else if (w_sh > WMAX) begin
        w_nxt = WMAX[F:0];
      end else begin
        w_nxt = w_sh[F:0];
      end
    end
    if (cmd.smul) begin
      sp_nxt = sample_r * $signed({1'b0, w_r});
    end
    if (cmd.out_load) begin
      res_nxt       = edge_r ? s_sat : sample_r;
      oend_nxt      = fend_r;
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      pos_r       <= pos_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sample_r <= sample_nxt;
    p_r      <= p_nxt;
    len_r    <= len_nxt;
    fend_r   <= fend_nxt;
    taper_r  <= taper_nxt;
    edge_r   <= edge_nxt;
    k_r      <= k_nxt;
    quad_r   <= quad_nxt;
    x_r      <= x_nxt;
    y_r      <= y_nxt;
    z_r      <= z_nxt;
    cos_r    <= cos_nxt;
    prod_r   <= prod_nxt;
    w_r      <= w_nxt;
    sp_r     <= sp_nxt;
    res_r    <= res_nxt;
    oend_r   <= oend_nxt;
  end

  assign sts.p_zero   = (p_r == '0);
  assign sts.edge_hit = edge_r;
  assign sts.out_full = out_valid_r && !out_ready;

  assign out_valid          = out_valid_r;
  assign out_tapered_sample = res_r;
  assign out_frame_end      = oend_r;

endmodule

>>> verif/hamming_edge_taper_tb.sv
// ---------------------------------------------------------------------------
// hamming_edge_taper_tb
// Self-checking bench for the edge taper block. Samples are driven through a
// valid/ready source channel, and a built-in window predictor tracks the
// frame position, the latched taper length and the CORDIC coefficient path.
// Every result beat is compared field by field with the oldest prediction.
// A directed part covers the corner cases, and random phases vary the frame
// setup and the idle and stall patterns on both channels.
// ---------------------------------------------------------------------------
module hamming_edge_taper_tb;
  import het_pkg::*;

  localparam int SW          = SAMPLE_BITS_DEF;
  localparam int CF          = COEF_FRAC_BITS_DEF;
  localparam int MAX_LEN     = MAX_FRAME_DEF;
  localparam int TOTAL_ITEMS = 1450;
  localparam int SETTLE_CYC  = 8;
  localparam int END_CYC     = 40;
  localparam int CYCLE_LIMIT = 1000000;

  localparam longint CORDIC_X_INIT = 64'sh26DD3B6A;
  localparam longint WIN_SCALE     = 64'sd493921239;
  localparam longint WIN_OFFSET    = 64'sd579820585;
  localparam logic signed [SW-1:0] SMAX = {1'b0, {(SW-1){1'b1}}};
  localparam logic signed [SW-1:0] SMIN = {1'b1, {(SW-1){1'b0}}};

  // Rotation angles atan(2^-i), in 2^-32 turn.
  localparam logic [31:0] ATAN_TURNS [0:19] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
    32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
    32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
    32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518
  };

  typedef struct packed {
    logic signed [SW-1:0] sample;
    logic                 frame_start;
  } taper_in_t;

  typedef struct packed {
    logic signed [SW-1:0] tapered_sample;
    logic                 frame_end;
  } taper_out_t;

  logic clk;
  logic rst_n;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  het_in_if  #(.SAMPLE_BITS(SW)) in_if ();
  het_out_if #(.SAMPLE_BITS(SW)) out_if ();

  hamming_edge_taper #(
    .MAX_FRAME      (MAX_LEN),
    .SAMPLE_BITS    (SW),
    .COEF_FRAC_BITS (CF)
  ) i_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_if.sink),
    .out_ch  (out_if.source),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  taper_in_t  pending_samples[$];
  taper_out_t expected_taps[$];
  int         fail_count = 0;
  int         pushed     = 0;
  int         send_idle_pct  = 0;
  int         recv_stall_pct = 0;
  longint     cycles = 0;

  // Mirror of the block's registers and frame state.
  int unsigned cfg_len;
  int unsigned cfg_frac;
  int unsigned frame_pos;
  int unsigned taper_len;
  logic [31:0] phase_inc;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic int unsigned eff_frame_len();
    int unsigned l;
    l = cfg_len;
    if (l == 0) l = 1;
    if (l > MAX_LEN) l = MAX_LEN;
    return l;
  endfunction

  function automatic void latch_taper_params();
    longint unsigned f;
    f = (cfg_frac > 32768) ? 64'd32768 : longint'(cfg_frac);
    taper_len = int'((longint'(eff_frame_len()) * f) >> 16);
    if (taper_len == 0) phase_inc = '0;
    else phase_inc = 32'((64'd1 << 32) / (2 * longint'(taper_len) - 1));
  endfunction

  // Cosine of a phase in 2^-32 turn, Q2.30.
  function automatic longint cordic_cos_q30(input logic [31:0] ph);
    longint x, y, z, dx, dy;
    int i;
    x = CORDIC_X_INIT;
    y = 0;
    z = longint'(ph[29:0]);
    for (i = 0; i < 20; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x = x - dx;
        y = y + dy;
        z = z - longint'(ATAN_TURNS[i]);
      end else begin
        x = x + dx;
        y = y - dy;
        z = z + longint'(ATAN_TURNS[i]);
      end
    end
    case (ph[31:30])
      2'd0:    return x;
      2'd1:    return -y;
      2'd2:    return -x;
      default: return y;
    endcase
  endfunction

  function automatic longint hamming_coef(input int unsigned k);
    logic [63:0] prod;
    longint c, w30, w;
    prod = 64'(k) * 64'(phase_inc);
    c    = cordic_cos_q30(prod[31:0]);
    w30  = WIN_OFFSET - ((WIN_SCALE * c + (64'sd1 <<< 29)) >>> 30);
    w    = (w30 + (64'sd1 <<< (29 - CF))) >>> (30 - CF);
    if (w < 0) w = 0;
    if (w > (64'sd1 <<< CF)) w = 64'sd1 <<< CF;
    return w;
  endfunction

  task automatic predict_taper(input taper_in_t it);
    longint      s, res;
    int unsigned len, p, k;
    bit          on_edge;
    taper_out_t  r;
    s       = longint'(it.sample);
    res     = s;
    len     = eff_frame_len();
    p       = frame_pos;
    on_edge = 1'b0;
    k       = 0;
    if (it.frame_start || p >= len) p = 0;
    if (p == 0) latch_taper_params();
    if (taper_len > 0) begin
      // A position below T always takes index p, even where the ends overlap.
      if (p < taper_len) begin
        on_edge = 1'b1;
        k = p;
      end else if (longint'(p) >= longint'(len) - longint'(taper_len)) begin
        on_edge = 1'b1;
        k = p - len + 2 * taper_len;
      end
      if (on_edge) begin
        res = (s * hamming_coef(k) + (64'sd1 <<< (CF - 1))) >>> CF;
        if (res > longint'(SMAX)) res = longint'(SMAX);
        if (res < longint'(SMIN)) res = longint'(SMIN);
      end
    end
    r.tapered_sample = res[SW-1:0];
    r.frame_end      = (p + 1 == len);
    expected_taps.push_back(r);
    frame_pos = (p + 1 >= len) ? 0 : p + 1;
  endtask

  // Driver: keeps a beat up until it is taken, then maybe idles.
  always @(posedge clk) begin : drv
    taper_in_t nxt;
    if (!rst_n) begin
      in_if.valid <= 1'b0;
    end else begin
      if (in_if.valid && in_if.ready) begin
        predict_taper('{sample: in_if.sample, frame_start: in_if.frame_start});
      end
      if (!in_if.valid || in_if.ready) begin
        if (pending_samples.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          nxt = pending_samples.pop_front();
          in_if.valid       <= 1'b1;
          in_if.sample      <= nxt.sample;
          in_if.frame_start <= nxt.frame_start;
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each result beat against the oldest prediction.
  always @(posedge clk) begin : mon
    taper_out_t want;
    if (!rst_n) begin
      out_if.ready <= 1'b0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        if (expected_taps.size() == 0) begin
          $error("unexpected result beat: tapered_sample %0d frame_end %0b",
                 out_if.tapered_sample, out_if.frame_end);
          fail_count++;
        end else begin
          want = expected_taps.pop_front();
          if (out_if.tapered_sample !== want.tapered_sample) begin
            $error("tapered_sample: expected %0d, got %0d",
                   want.tapered_sample, out_if.tapered_sample);
            fail_count++;
          end
          if (out_if.frame_end !== want.frame_end) begin
            $error("frame_end: expected %0b, got %0b", want.frame_end, out_if.frame_end);
            fail_count++;
          end
        end
      end
      out_if.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  task automatic set_idling(input int mode);
    case (mode)
      0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      1: begin send_idle_pct = 51; recv_stall_pct = 0;  end
      2: begin send_idle_pct = 0;  recv_stall_pct = 51; end
      default: begin send_idle_pct = 28; recv_stall_pct = 28; end
    endcase
  endtask

  // The queues and the valid line are looked at on the falling edge, after the
  // driver and the monitor have settled for the cycle.
  task automatic wait_for_drain();
    do @(negedge clk);
    while (pending_samples.size() > 0 || in_if.valid || expected_taps.size() > 0);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  task automatic cfg_write(input het_reg_t r, input int unsigned v);
    wait_for_drain();
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_W'(4 * int'(r));
    pwdata  <= DATA_W'(v);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (r == REG_FRAME_LENGTH) cfg_len = v & 32'h1FFFF;
    else cfg_frac = v & 32'hFFFF;
  endtask

  task automatic push_item(input logic signed [SW-1:0] s, input logic fs);
    pending_samples.push_back('{sample: s, frame_start: fs});
    pushed++;
  endtask

  task automatic push_random_item(input bit first);
    logic signed [SW-1:0] s;
    logic                 fs;
    case ($urandom_range(19))
      0:       s = SMAX;
      1:       s = SMIN;
      2:       s = '0;
      3:       s = '1;
      default: s = SW'($urandom);
    endcase
    // Phases usually open a fresh frame; stray frame starts appear mid-frame too.
    fs = first ? ($urandom_range(3) != 0) : ($urandom_range(99) < 4);
    push_item(s, fs);
  endtask

  function automatic int unsigned pick_frame_len();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 55) return $urandom_range(1, 24);
    if (r < 75) return $urandom_range(25, 200);
    if (r < 88) begin
      case ($urandom_range(7))
        0: return 0;
        1: return 1;
        2: return 2;
        3: return 3;
        4: return MAX_LEN - 1;
        5: return MAX_LEN;
        6: return MAX_LEN + 1;
        default: return 32'h1FFFF;
      endcase
    end
    return $urandom_range(0, 32'h1FFFF);
  endfunction

  function automatic int unsigned pick_fraction();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 12) return 0;
    if (r < 27) return 32768;
    if (r < 37) return 65535;
    if (r < 42) return 1;
    if (r < 47) return 32769;
    return $urandom_range(0, 65535);
  endfunction

  initial begin : stim
    int phase_idx, n, j, pause_at;
    rst_n             = 1'b0;
    psel              = 1'b0;
    penable           = 1'b0;
    pwrite            = 1'b0;
    paddr             = '0;
    pwdata            = '0;
    in_if.valid       = 1'b0;
    in_if.sample      = '0;
    in_if.frame_start = 1'b0;
    out_if.ready      = 1'b0;
    cfg_len           = 1024;
    cfg_frac          = 3277;
    frame_pos         = 0;
    latch_taper_params();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset setup: the first samples of a frame sit on the rising edge.
    push_item(SMAX, 1'b1);
    push_item(SMIN, 1'b0);
    push_item('0, 1'b0);
    push_item('1, 1'b0);
    push_item(SW'(1), 1'b0);
    push_item(SW'($urandom), 1'b0);

    // Zero length acts as one; a fraction above one half is clamped.
    cfg_write(REG_FRAME_LENGTH, 0);
    cfg_write(REG_TAPER_FRACTION, 65535);
    push_item(SMAX, 1'b0);
    push_item(SMIN, 1'b0);

    // One tapered sample per end: both edges get the minimum weight.
    cfg_write(REG_FRAME_LENGTH, 2);
    cfg_write(REG_TAPER_FRACTION, 32768);
    push_item(SMAX, 1'b1);
    push_item(SMIN, 1'b0);
    push_item(SMAX, 1'b0);

    // Oversized length saturates to the maximum frame; zero fraction passes.
    cfg_write(REG_FRAME_LENGTH, 32'h1FFFF);
    cfg_write(REG_TAPER_FRACTION, 0);
    push_item(SMIN, 1'b1);
    push_item(SW'($urandom), 1'b0);

    // Shrinking the length mid-frame keeps the latched zero taper and ends the frame at the new length.
    cfg_write(REG_FRAME_LENGTH, 16);
    cfg_write(REG_TAPER_FRACTION, 32768);
    repeat (5) push_item(SW'($urandom), 1'b0);
    cfg_write(REG_FRAME_LENGTH, 8);
    repeat (2) push_item(SW'($urandom), 1'b0);

    // A position beyond a shrunken length restarts the frame.
    cfg_write(REG_FRAME_LENGTH, 16);
    repeat (3) push_item(SW'($urandom), 1'b0);
    cfg_write(REG_FRAME_LENGTH, 2);
    repeat (2) push_item(SW'($urandom), 1'b0);

    phase_idx = 0;
    while (pushed < TOTAL_ITEMS) begin
      set_idling(phase_idx % 4);
      if ($urandom_range(9) < 8) begin
        if ($urandom_range(9) < 7) cfg_write(REG_FRAME_LENGTH, pick_frame_len());
        if ($urandom_range(9) < 7) cfg_write(REG_TAPER_FRACTION, pick_fraction());
      end
      n = $urandom_range(20, 80);
      pause_at = (phase_idx == 0 || $urandom_range(9) == 0) ? $urandom_range(1, n - 1) : n;
      for (j = 0; j < n; j++) begin
        // The sender holds off here until every outstanding result is back.
        if (j == pause_at) wait_for_drain();
        push_random_item(j == 0);
      end
      phase_idx++;
    end

    wait_for_drain();
    repeat (END_CYC) @(posedge clk);
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

>>> sim.f
+incdir+hw/rtl
hw/rtl/het_pkg.sv
hw/rtl/het_in_if.sv
hw/rtl/het_out_if.sv
hw/rtl/het_div.sv
hw/rtl/het_ctrl.sv
hw/rtl/het_dpath.sv
hw/rtl/hamming_edge_taper.sv
verif/hamming_edge_taper_tb.sv
